// ===== hdl/crpe_pkg.sv =====
// Shared constants for the column run peak extractor.
package crpe_pkg;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 1024;
    localparam int DEF_MAX_DIVISIONS = 4;

    // Field widths
    localparam int PIXEL_W  = 8;
    localparam int OUT_POS_W = 10;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_DIV_W  = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int TDATA_OUT_W = 24;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DIVISIONS    = 2'd2;

    // Register reset values
    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [CFG_SIZE_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [CFG_DIV_W-1:0]  RST_DIVISIONS    = 3'd2;

    // Result kinds
    localparam logic KIND_COLUMN = 1'b0;
    localparam logic KIND_GROUP  = 1'b1;

endpackage

// ===== hdl/column_run_peak_extractor.sv =====
// Top level of the column run peak extractor: run tracking, group store and rank selection.
//
// Pixels arrive column-major, one beat per cycle, and the block takes one pixel every cycle
// except after the last pixel of a column, while it hands over the column result, and, when
// that pixel closes a group of 2^d+1 columns before the end of the image, while a single key
// comparator ranks the stored group entries against each other, reading the group store
// through its one registered read port. A result waiting in the output register does not
// stall pixels that end no column. Results leave as kind 0 (column peak) and kind 1 (group
// pick); tlast marks the final result of a pixel.
module column_run_peak_extractor #(
    parameter int MAX_WIDTH     = crpe_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = crpe_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_DIVISIONS = crpe_pkg::DEF_MAX_DIVISIONS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // pixel stream; tdata: pixel[7:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [crpe_pkg::PIXEL_W-1:0]      s_tdata,
    // result stream; tdata: column[9:0], row[19:10], found[20], zero pad [23:21]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [crpe_pkg::TDATA_OUT_W-1:0]  m_tdata,
    // tuser: kind[0]
    output logic                              m_tuser,
    output logic                              m_tlast,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crpe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [crpe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [crpe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int ROWW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int GD   = (2 ** MAX_DIVISIONS) + 1;
    localparam int GIW  = $clog2(GD);
    localparam int KW   = crpe_pkg::OUT_POS_W + COLW + GIW;
    localparam int EW   = crpe_pkg::OUT_POS_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_COL,
        ST_FETCH_I,
        ST_WAIT_I,
        ST_CMP,
        ST_EMIT_GRP
    } state_t;

    // Configuration registers
    logic [crpe_pkg::CFG_SIZE_W-1:0] width_cfg_reg;
    logic [crpe_pkg::CFG_SIZE_W-1:0] height_cfg_reg;
    logic [crpe_pkg::CFG_DIV_W-1:0]  div_cfg_reg;
    logic                            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= crpe_pkg::RST_IMAGE_WIDTH;
            height_cfg_reg <= crpe_pkg::RST_IMAGE_HEIGHT;
            div_cfg_reg    <= crpe_pkg::RST_DIVISIONS;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                crpe_pkg::REG_IMAGE_WIDTH:
                    width_cfg_reg <= pwdata[crpe_pkg::CFG_SIZE_W-1:0];
                crpe_pkg::REG_IMAGE_HEIGHT:
                    height_cfg_reg <= pwdata[crpe_pkg::CFG_SIZE_W-1:0];
                crpe_pkg::REG_DIVISIONS:
                    div_cfg_reg <= pwdata[crpe_pkg::CFG_DIV_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode register reads
    always_comb begin
        unique case (paddr[3:2])
            crpe_pkg::REG_IMAGE_WIDTH:
                prdata = crpe_pkg::APB_DATA_W'(width_cfg_reg);
            crpe_pkg::REG_IMAGE_HEIGHT:
                prdata = crpe_pkg::APB_DATA_W'(height_cfg_reg);
            crpe_pkg::REG_DIVISIONS:
                prdata = crpe_pkg::APB_DATA_W'(div_cfg_reg);
            default:
                prdata = '0;
        endcase
    end

    // Clamp limits to their legal ranges
    logic [COLW:0]                  w_lim;
    logic [ROWW:0]                  h_lim;
    logic [crpe_pkg::CFG_DIV_W-1:0] d_lim;
    logic [GIW:0]                   gsize;
    logic [GIW:0]                   rank;

    always_comb begin
        if (width_cfg_reg == '0)
            w_lim = (COLW+1)'(1);
        else if (width_cfg_reg > MAX_WIDTH)
            w_lim = (COLW+1)'(MAX_WIDTH);
        else
            w_lim = (COLW+1)'(width_cfg_reg);
        if (height_cfg_reg == '0)
            h_lim = (ROWW+1)'(1);
        else if (height_cfg_reg > MAX_HEIGHT)
            h_lim = (ROWW+1)'(MAX_HEIGHT);
        else
            h_lim = (ROWW+1)'(height_cfg_reg);
        d_lim = (div_cfg_reg > MAX_DIVISIONS) ? crpe_pkg::CFG_DIV_W'(MAX_DIVISIONS)
                                              : div_cfg_reg;
        gsize = (GIW+1)'((1 << d_lim) + 1);
        rank  = (d_lim == '0) ? '0 : (GIW+1)'(1 << (d_lim - 1'b1));
    end

    // State and registered outputs
    state_t               state_reg, state_next;
    logic                 in_run_reg, in_run_next;
    logic [7:0]           run_v_reg, run_v_next;
    logic [ROWW-1:0]      run_r_reg, run_r_next;
    logic [7:0]           best_v_reg, best_v_next;
    logic [ROWW-1:0]      best_r_reg, best_r_next;
    logic [ROWW-1:0]      row_cnt_reg, row_cnt_next;
    logic [COLW-1:0]      col_cnt_reg, col_cnt_next;
    logic [GIW-1:0]       fill_reg, fill_next;
    // pending column result and group job
    logic [EW-1:0]        col_entry_reg, col_entry_next;
    logic [9:0]           col_pos_reg, col_pos_next;
    logic                 grp_pend_reg, grp_pend_next;
    logic [COLW-1:0]      start_reg, start_next;
    logic [GIW-1:0]       last_idx_reg, last_idx_next;
    logic [GIW:0]         rank_reg, rank_next;
    // selection sequencer
    logic [GIW-1:0]       i_reg, i_next;
    logic [GIW-1:0]       j_reg, j_next;
    logic [GIW:0]         below_reg, below_next;
    logic [KW-1:0]        key_i_reg, key_i_next;
    logic [EW-1:0]        ent_i_reg, ent_i_next;
    logic [EW-1:0]        sel_ent_reg, sel_ent_next;
    logic [GIW-1:0]       sel_idx_reg, sel_idx_next;
    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [9:0]           out_col_reg, out_col_next;
    logic [EW-1:0]        out_ent_reg, out_ent_next;
    logic                 out_last_reg, out_last_next;

    // Group store
    logic [EW-1:0]        gp_mem [GD];
    logic                 mem_we;
    logic [GIW-1:0]       mem_waddr;
    logic [EW-1:0]        mem_wdata;
    logic [GIW-1:0]       mem_raddr;
    logic [EW-1:0]        mem_rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we)
            gp_mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= gp_mem[mem_raddr];
    end

    // Sort key: row, then reported column, then position in the group
    function automatic logic [KW-1:0] key_of(input logic [EW-1:0] ent,
                                             input logic [COLW-1:0] start,
                                             input logic [GIW-1:0] idx);
        logic [COLW-1:0] col;
        col = ent[EW-1] ? (start + COLW'(idx)) : '0;
        return {ent[9:0], col, idx};
    endfunction

    logic                 accept;
    logic                 out_free;
    logic                 p_nz;
    logic                 col_end;
    logic                 found;
    logic                 grp_done;
    logic [GIW:0]         fill_inc;
    logic [KW-1:0]        key_j;
    logic                 key_less;
    logic [GIW:0]         below_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign p_nz     = (s_tdata != '0);
    assign fill_inc = {1'b0, fill_reg} + 1'b1;

    // Shared comparator
    assign key_j     = key_of(mem_rdata_reg, start_reg, j_reg);
    assign key_less  = (key_j < key_i_reg);
    assign below_sum = below_reg + (GIW+1)'(key_less);

    always_comb begin
        state_next     = state_reg;
        in_run_next    = in_run_reg;
        run_v_next     = run_v_reg;
        run_r_next     = run_r_reg;
        best_v_next    = best_v_reg;
        best_r_next    = best_r_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        fill_next      = fill_reg;
        col_entry_next = col_entry_reg;
        col_pos_next   = col_pos_reg;
        grp_pend_next  = grp_pend_reg;
        start_next     = start_reg;
        last_idx_next  = last_idx_reg;
        rank_next      = rank_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        below_next     = below_reg;
        key_i_next     = key_i_reg;
        ent_i_next     = ent_i_reg;
        sel_ent_next   = sel_ent_reg;
        sel_idx_next   = sel_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_col_next   = out_col_reg;
        out_ent_next   = out_ent_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_reg;
        mem_wdata      = col_entry_reg;
        mem_raddr      = '0;
        col_end        = 1'b0;
        found          = 1'b0;
        grp_done       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // open or close a run, then track its peak
                    if (p_nz && !in_run_next) begin
                        in_run_next = 1'b1;
                        run_v_next  = '0;
                        run_r_next  = '0;
                    end
                    if (!p_nz && in_run_next) begin
                        in_run_next = 1'b0;
                        if (run_v_next > best_v_next) begin
                            best_v_next = run_v_next;
                            best_r_next = run_r_next;
                        end
                    end
                    if (in_run_next && s_tdata > run_v_next) begin
                        run_v_next = s_tdata;
                        run_r_next = row_cnt_reg;
                    end

                    col_end = ({1'b0, row_cnt_reg} + 1'b1) >= h_lim;
                    if (!col_end) begin
                        row_cnt_next = row_cnt_reg + 1'b1;
                    end else begin
                        // column result and group entry
                        found          = (best_v_next != '0);
                        col_entry_next = {found, found ? 10'(best_r_next) : 10'd0};
                        col_pos_next   = found ? 10'(col_cnt_reg) : 10'd0;
                        mem_we         = 1'b1;
                        mem_waddr      = fill_reg;
                        mem_wdata      = col_entry_next;
                        in_run_next    = 1'b0;
                        run_v_next     = '0;
                        run_r_next     = '0;
                        best_v_next    = '0;
                        best_r_next    = '0;
                        row_cnt_next   = '0;

                        // close the group when full
                        grp_done      = (fill_inc >= gsize) || (fill_inc >= (GIW+1)'(GD));
                        grp_pend_next = grp_done &&
                                        (({1'b0, col_cnt_reg} + 1'b1) < w_lim);
                        start_next    = col_cnt_reg - COLW'(fill_reg);
                        last_idx_next = fill_reg;
                        rank_next     = rank;
                        fill_next     = grp_done ? '0 : GIW'(fill_inc);

                        // advance column, restart at image end
                        if (({1'b0, col_cnt_reg} + 1'b1) >= w_lim) begin
                            col_cnt_next = '0;
                            fill_next    = '0;
                        end else begin
                            col_cnt_next = col_cnt_reg + 1'b1;
                        end
                        state_next = ST_EMIT_COL;
                    end
                end
            end

            ST_EMIT_COL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = crpe_pkg::KIND_COLUMN;
                    out_col_next   = col_pos_reg;
                    out_ent_next   = col_entry_reg;
                    out_last_next  = !grp_pend_reg;
                    i_next         = '0;
                    state_next     = grp_pend_reg ? ST_FETCH_I : ST_IDLE;
                end
            end

            ST_FETCH_I: begin
                mem_raddr  = i_reg;
                state_next = ST_WAIT_I;
            end

            ST_WAIT_I: begin
                // latch candidate, start scan at entry 0
                key_i_next = key_of(mem_rdata_reg, start_reg, i_reg);
                ent_i_next = mem_rdata_reg;
                if (i_reg == '0) begin
                    sel_ent_next = mem_rdata_reg;
                    sel_idx_next = '0;
                end
                mem_raddr  = '0;
                j_next     = '0;
                below_next = '0;
                state_next = ST_CMP;
            end

            ST_CMP: begin
                if (j_reg == last_idx_reg) begin
                    if (below_sum == rank_reg) begin
                        sel_ent_next = ent_i_reg;
                        sel_idx_next = i_reg;
                    end
                    if (i_reg == last_idx_reg) begin
                        state_next = ST_EMIT_GRP;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_FETCH_I;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    mem_raddr  = j_reg + 1'b1;
                    below_next = below_sum;
                end
            end

            ST_EMIT_GRP: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = crpe_pkg::KIND_GROUP;
                    out_col_next   = sel_ent_reg[EW-1]
                                     ? 10'(start_reg + COLW'(sel_idx_reg)) : 10'd0;
                    out_ent_next   = sel_ent_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            in_run_reg    <= 1'b0;
            run_v_reg     <= '0;
            run_r_reg     <= '0;
            best_v_reg    <= '0;
            best_r_reg    <= '0;
            row_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            fill_reg      <= '0;
            grp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            in_run_reg    <= in_run_next;
            run_v_reg     <= run_v_next;
            run_r_reg     <= run_r_next;
            best_v_reg    <= best_v_next;
            best_r_reg    <= best_r_next;
            row_cnt_reg   <= row_cnt_next;
            col_cnt_reg   <= col_cnt_next;
            fill_reg      <= fill_next;
            grp_pend_reg  <= grp_pend_next;
            out_valid_reg <= out_valid_next;
        end
        // payload
        col_entry_reg <= col_entry_next;
        col_pos_reg   <= col_pos_next;
        start_reg     <= start_next;
        last_idx_reg  <= last_idx_next;
        rank_reg      <= rank_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        below_reg     <= below_next;
        key_i_reg     <= key_i_next;
        ent_i_reg     <= ent_i_next;
        sel_ent_reg   <= sel_ent_next;
        sel_idx_reg   <= sel_idx_next;
        out_kind_reg  <= out_kind_next;
        out_col_reg   <= out_col_next;
        out_ent_reg   <= out_ent_next;
        out_last_reg  <= out_last_next;
    end

    // Drive result ports
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_ent_reg[EW-1], out_ent_reg[9:0], out_col_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/crpe_checker.sv =====
// Port-level checker for the column run peak extractor, bound to the top level.
module crpe_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [crpe_pkg::TDATA_OUT_W-1:0] m_tdata,
    input logic                             m_tuser,
    input logic                             m_tlast
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result beat changed");

    // Reset drops the result channel
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A group pick is always the final result of its pixel
    a_group_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == crpe_pkg::KIND_GROUP) |-> m_tlast)
        else $error("group result without tlast");

    // A point without a closed run reports column 0 and row 0
    a_empty_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[20] |-> (m_tdata[19:0] == 20'd0))
        else $error("empty point with nonzero position");

endmodule

bind column_run_peak_extractor crpe_checker u_crpe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/column_run_peak_extractor_tb.sv =====
// Self-checking testbench for the column run peak extractor: stream stimulus, APB setup, scoreboard.
module column_run_peak_extractor_tb;

    localparam int MAX_W         = crpe_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H         = crpe_pkg::DEF_MAX_HEIGHT;
    localparam int MAX_D         = crpe_pkg::DEF_MAX_DIVISIONS;
    localparam int GROUP_DEPTH   = (1 << crpe_pkg::DEF_MAX_DIVISIONS) + 1;
    // settle time that covers the longest group ranking, with margin on top
    localparam int SETTLE_CYCLES = 400;
    localparam int LIMIT_CYCLES  = 2_000_000;

    typedef struct packed {
        logic                           kind;
        logic [crpe_pkg::OUT_POS_W-1:0] column;
        logic [crpe_pkg::OUT_POS_W-1:0] row;
        logic                           found;
        logic                           last;
    } peak_result_t;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

    // DUT signals; the driven inputs are known from time zero
    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [crpe_pkg::PIXEL_W-1:0]     s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [crpe_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [crpe_pkg::APB_ADDR_W-1:0]  paddr    = '0;
    logic [crpe_pkg::APB_DATA_W-1:0]  pwdata   = '0;
    logic [crpe_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;

    // scoreboard
    peak_result_t pending_peaks[$];
    peak_result_t mon_exp;
    int unsigned  errors = 0;
    int unsigned  cycle_count = 0;

    // idling control
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_len     = 0;
    int unsigned hold_id      = 0;
    int unsigned seen_hold_id = 0;
    int unsigned rx_hold_left = 0;

    // pixel generator state
    logic         burst_on     = 1'b0;
    logic [7:0]   last_run_val = 8'd128;

    // predictor copy of configuration and state
    logic [crpe_pkg::CFG_SIZE_W-1:0] cfg_width  = crpe_pkg::RST_IMAGE_WIDTH;
    logic [crpe_pkg::CFG_SIZE_W-1:0] cfg_height = crpe_pkg::RST_IMAGE_HEIGHT;
    logic [crpe_pkg::CFG_DIV_W-1:0]  cfg_div    = crpe_pkg::RST_DIVISIONS;
    logic                            in_run     = 1'b0;
    logic [7:0]                      run_val    = '0;
    logic [9:0]                      run_row    = '0;
    logic [7:0]                      best_val   = '0;
    logic [9:0]                      best_row   = '0;
    logic [9:0]                      row_cnt    = '0;
    logic [9:0]                      col_cnt    = '0;
    logic [4:0]                      grp_fill   = '0;
    logic [10:0]                     grp_store [GROUP_DEPTH];

    column_run_peak_extractor u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Compute the results one accepted pixel causes and queue them
    task automatic predict_pixel(input logic [7:0] p);
        int unsigned  w, h, d, gsize, cnt, start, rank, sel, below, colk;
        int unsigned  keys [GROUP_DEPTH];
        logic [10:0]  e;
        logic         found;
        logic [9:0]   row;
        peak_result_t col_res, grp_res;
        logic         has_grp;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
        h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_H) ? MAX_H : cfg_height);
        d = (cfg_div > MAX_D) ? MAX_D : cfg_div;
        gsize = (1 << d) + 1;
        has_grp = 1'b0;

        // track runs within the column
        if (p != 0 && !in_run) begin
            in_run  = 1'b1;
            run_val = '0;
            run_row = '0;
        end
        if (p == 0 && in_run) begin
            in_run = 1'b0;
            if (run_val > best_val) begin
                best_val = run_val;
                best_row = run_row;
            end
        end
        if (in_run && p > run_val) begin
            run_val = p;
            run_row = row_cnt;
        end

        if (row_cnt + 1 < h) begin
            row_cnt = row_cnt + 1;
            return;
        end

        // column ends: report the brightest closed run
        found = (best_val > 0);
        row   = found ? best_row : '0;
        col_res = '{kind: crpe_pkg::KIND_COLUMN, column: found ? col_cnt : '0, row: row,
                    found: found, last: 1'b0};
        if (grp_fill < GROUP_DEPTH)
            grp_store[grp_fill] = {found, row};
        in_run   = 1'b0;
        run_val  = '0;
        run_row  = '0;
        best_val = '0;
        best_row = '0;
        row_cnt  = '0;

        // group closes: pick the entry at the target rank
        if (grp_fill + 1 >= gsize || grp_fill + 1 >= GROUP_DEPTH) begin
            if (col_cnt + 1 < w) begin
                cnt   = grp_fill + 1;
                start = col_cnt - grp_fill;
                rank  = (d == 0) ? 0 : (1 << (d - 1));
                sel   = 0;
                for (int unsigned i = 0; i < cnt; i++) begin
                    e = grp_store[i];
                    colk = e[10] ? ((start + i) & 32'hFFFF) : 0;
                    keys[i] = (int'(e[9:0]) << 21) | (colk << 5) | i;
                end
                for (int unsigned i = 0; i < cnt; i++) begin
                    below = 0;
                    for (int unsigned j = 0; j < cnt; j++)
                        if (keys[j] < keys[i]) below++;
                    if (below == rank) sel = i;
                end
                e = grp_store[sel];
                grp_res = '{kind: crpe_pkg::KIND_GROUP,
                            column: e[10] ? 10'(start + sel) : 10'd0,
                            row: e[9:0], found: e[10], last: 1'b1};
                has_grp = 1'b1;
            end
            grp_fill = '0;
        end else begin
            grp_fill = grp_fill + 1;
        end

        // advance the column, wrap at image end
        if (col_cnt + 1 >= w) begin
            col_cnt  = '0;
            grp_fill = '0;
        end else begin
            col_cnt = col_cnt + 1;
        end

        col_res.last = !has_grp;
        pending_peaks.insert(pending_peaks.size(), col_res);
        if (has_grp)
            pending_peaks.insert(pending_peaks.size(), grp_res);
    endtask

    // Offer one pixel beat, with random gaps, and predict once accepted
    task automatic send_pixel(input logic [7:0] p);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(p);
    endtask

    // Mostly runs of nonzero pixels between background, some noise
    function automatic logic [7:0] gen_pixel();
        logic [7:0] v;
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 30)
            burst_on = !burst_on;
        if (!burst_on)
            return 8'd0;
        case ($urandom_range(0, 4))
            0:       v = 8'd255;
            1:       v = 8'd1;
            2:       v = last_run_val;
            default: v = 8'($urandom_range(1, 255));
        endcase
        last_run_val = v;
        return v;
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_TX:   begin tx_idle_pct = 56; rx_stall_pct = 0;  end
            IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 56; end
            default:   begin tx_idle_pct = 21; rx_stall_pct = 21; end
        endcase
    endtask

    // Stop offering pixels and wait for every queued result
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_peaks.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [1:0] idx,
                             input logic [crpe_pkg::APB_DATA_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            crpe_pkg::REG_IMAGE_WIDTH:  cfg_width  = val[crpe_pkg::CFG_SIZE_W-1:0];
            crpe_pkg::REG_IMAGE_HEIGHT: cfg_height = val[crpe_pkg::CFG_SIZE_W-1:0];
            crpe_pkg::REG_DIVISIONS:    cfg_div    = val[crpe_pkg::CFG_DIV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apb_check_read(input logic [1:0] idx,
                                  input logic [crpe_pkg::APB_DATA_W-1:0] exp_val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== exp_val) begin
            $display("%0t: register %0d read mismatch, expected %0d actual %0d",
                     $time, idx, exp_val, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reconfigure only with the pipeline empty and settled
    task automatic configure_sizes(input logic [crpe_pkg::APB_DATA_W-1:0] w,
                                   input logic [crpe_pkg::APB_DATA_W-1:0] h,
                                   input logic [crpe_pkg::APB_DATA_W-1:0] d);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_write(crpe_pkg::REG_IMAGE_WIDTH, w);
        apb_write(crpe_pkg::REG_IMAGE_HEIGHT, h);
        apb_write(crpe_pkg::REG_DIVISIONS, d);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare every result beat against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_peaks.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                mon_exp = pending_peaks.pop_front();
                check_field("kind", int'(mon_exp.kind), int'(m_tuser));
                check_field("column", int'(mon_exp.column), int'(m_tdata[9:0]));
                check_field("row", int'(mon_exp.row), int'(m_tdata[19:10]));
                check_field("found", int'(mon_exp.found), int'(m_tdata[20]));
                check_field("last", int'(mon_exp.last), int'(m_tlast));
            end
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_id != seen_hold_id) begin
            seen_hold_id = hold_id;
            rx_hold_left = hold_len;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset values read back, then the directed geometry written
    task automatic test_register_access();
        apb_check_read(crpe_pkg::REG_IMAGE_WIDTH,
                       crpe_pkg::APB_DATA_W'(crpe_pkg::RST_IMAGE_WIDTH));
        apb_check_read(crpe_pkg::REG_IMAGE_HEIGHT,
                       crpe_pkg::APB_DATA_W'(crpe_pkg::RST_IMAGE_HEIGHT));
        apb_check_read(crpe_pkg::REG_DIVISIONS,
                       crpe_pkg::APB_DATA_W'(crpe_pkg::RST_DIVISIONS));
        configure_sizes(4, 6, 0);
        apb_check_read(crpe_pkg::REG_IMAGE_WIDTH, 4);
        apb_check_read(crpe_pkg::REG_IMAGE_HEIGHT, 6);
        apb_check_read(crpe_pkg::REG_DIVISIONS, 0);
    endtask

    // Extremes, ties, an unclosed run, an empty column, last group of image
    task automatic test_column_runs();
        logic [7:0] seq [24] = '{
            8'd0,   8'd5, 8'd9,   8'd9, 8'd0, 8'd0,
            8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd7,
            8'd1,   8'd1, 8'd1,   8'd1, 8'd1, 8'd1,
            8'd0,   8'd0, 8'd0,   8'd0, 8'd0, 8'd0};
        set_idle(IDLE_NONE);
        foreach (seq[i]) send_pixel(seq[i]);
    endtask

    // All-ones writes: masked to field width, then clamped to the maxima
    task automatic test_size_clamp();
        logic [7:0] p;
        configure_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        apb_check_read(crpe_pkg::REG_IMAGE_WIDTH, 2047);
        apb_check_read(crpe_pkg::REG_IMAGE_HEIGHT, 2047);
        apb_check_read(crpe_pkg::REG_DIVISIONS, 7);
        set_idle(IDLE_RX);
        // tall column ends at the clamped height; the bright run near the bottom wins
        for (int i = 0; i < MAX_H + 6; i++) begin
            if (i < MAX_H - 4)       p = gen_pixel() >> 1;
            else if (i == MAX_H - 3) p = 8'd254;
            else if (i == MAX_H - 2) p = 8'd255;
            else if (i < MAX_H)      p = 8'd0;
            else                     p = gen_pixel();
            send_pixel(p);
        end
    endtask

    // Zero sizes act as one: every pixel closes a column and an image
    task automatic test_zero_sizes();
        configure_sizes(0, 0, 5);
        set_idle(IDLE_BOTH);
        repeat (8) send_pixel(gen_pixel());
    endtask

    // Shrink limits in the middle of a column, a group and an image
    task automatic test_midimage_changes();
        configure_sizes(8, 8, 2);
        set_idle(IDLE_TX);
        repeat (28) send_pixel(gen_pixel());
        configure_sizes(8, 3, 2);
        repeat (4) send_pixel(gen_pixel());
        configure_sizes(8, 3, 0);
        repeat (3) send_pixel(gen_pixel());
        configure_sizes(2, 3, 0);
        repeat (9) send_pixel(gen_pixel());
    endtask

    // Hold the result side off long enough to stall the pixel side
    task automatic test_output_backpressure();
        configure_sizes(10, 2, 1);
        set_idle(IDLE_NONE);
        hold_len = 300;
        hold_id  = hold_id + 1;
        repeat (60) send_pixel(gen_pixel());
        // pause the sender until every result is out
        wait_results_drained();
        set_idle(IDLE_BOTH);
        repeat (20) send_pixel(gen_pixel());
    endtask

    // Random content across several geometries and idling patterns
    task automatic test_random_streams();
        int unsigned widths  [8] = '{6, 12, 40, 4, 20, 9, 35, 7};
        int unsigned heights [8] = '{5, 3, 2, 4, 2, 6, 1, 3};
        int unsigned divs    [8] = '{1, 2, 4, 0, 3, 2, 4, 3};
        for (int ph = 0; ph < 8; ph++) begin
            configure_sizes(widths[ph], heights[ph], divs[ph]);
            set_idle(idle_mode_t'(ph % 4));
            repeat (90) send_pixel(gen_pixel());
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_column_runs();
        test_size_clamp();
        test_zero_sizes();
        test_midimage_changes();
        test_output_backpressure();
        test_random_streams();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_peaks.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_peaks.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
